// ----- rtl/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table: entry layout,
// scan result bundle, opcodes and register map.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Request opcodes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // Register map: register index sits at paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam int          CAP_W       = 5;
  localparam logic [4:0]  CAP_RESET   = 5'd16;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_ONE   = 32'd1;
  localparam logic [31:0] MISS_VALUE  = 32'hFFFF_FFFF;

  // One stored cache entry
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] use_count;
    logic [63:0] last_access;
  } entry_t;

  // Key match found during a scan
  typedef struct packed {
    logic        hit;
    logic [31:0] hit_value;
    logic [31:0] hit_count;
  } scan_res_t;

endpackage

// ----- rtl/lfu_mem.sv -----
// ----------------------------------------------------------------------------
// lfu_mem
// Simple dual-port entry store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lfu_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  lfu_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output lfu_pkg::entry_t  rdata_o
);
  import lfu_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lfu_scan.sv -----
// ----------------------------------------------------------------------------
// lfu_scan
// Walks the entries streamed out of the store: finds the key match and
// tracks the eviction victim (lowest count, oldest access on a tie).
// ----------------------------------------------------------------------------
module lfu_scan #(
  parameter int IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 rd_vld_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  input  lfu_pkg::entry_t      rd_data_i,
  input  logic [31:0]          key_i,
  output lfu_pkg::scan_res_t   res_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     victim_idx_o
);
  import lfu_pkg::*;

  logic             hit_q, hit_d;
  logic [31:0]      hit_value_q, hit_count_q;
  logic [IDX_W-1:0] hit_idx_q, victim_idx_q;
  logic             have_best_q, have_best_d;
  logic [31:0]      best_count_q;
  logic [63:0]      best_stamp_q;
  logic             key_match, better;

  assign key_match = rd_vld_i && (rd_data_i.key == key_i);

  // strict compare keeps the earliest index on a full tie
  assign better = rd_vld_i &&
                  (!have_best_q ||
                   (rd_data_i.use_count < best_count_q) ||
                   ((rd_data_i.use_count == best_count_q) &&
                    (rd_data_i.last_access < best_stamp_q)));

  always_comb begin
    hit_d       = hit_q;
    have_best_d = have_best_q;
    if (clear_i) begin
      hit_d       = 1'b0;
      have_best_d = 1'b0;
    end else begin
      if (key_match) hit_d = 1'b1;
      if (better)    have_best_d = 1'b1;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      have_best_q <= 1'b0;
    end else begin
      hit_q       <= hit_d;
      have_best_q <= have_best_d;
    end
  end

  // match and victim payload
  always_ff @(posedge clk_i) begin
    if (key_match) begin
      hit_idx_q   <= rd_idx_i;
      hit_value_q <= rd_data_i.value;
      hit_count_q <= rd_data_i.use_count;
    end
    if (better) begin
      victim_idx_q <= rd_idx_i;
      best_count_q <= rd_data_i.use_count;
      best_stamp_q <= rd_data_i.last_access;
    end
  end

  assign res_o.hit       = hit_q;
  assign res_o.hit_value = hit_value_q;
  assign res_o.hit_count = hit_count_q;
  assign hit_idx_o       = hit_idx_q;
  assign victim_idx_o    = victim_idx_q;

endmodule

// ----- rtl/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value cache with least-frequently-used replacement and
// least-recently-used tie-break.
// ----------------------------------------------------------------------------
// One request at a time. Entries live in a single-port-read memory; a request
// reads every occupied entry once (one per cycle) to find its key and the
// eviction victim, then writes back at most one entry. An empty table skips
// the scan and the flush state. The write-back waits while the previous
// result is still held. The result sits in an output register, so a new
// request can be accepted while the previous result waits. Valid entries
// always form the prefix 0 .. occupied-1, so no clearing pass is needed after
// reset. Capacity is register 0 (paddr[2] = 0); values above ENTRIES act as
// ENTRIES, zero makes puts do nothing.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [31:0] read_value_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT
  } state_e;

  state_e           state_q, state_d;
  logic [OCC_W-1:0] cnt_q, cnt_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [63:0]      clock_q, clock_d;
  logic [CAP_W-1:0] cap_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             out_valid_q, out_valid_d;
  logic             hit_q, hit_d;
  logic [31:0]      rdv_q, rdv_d;

  // latched request
  logic             op_q;
  logic [31:0]      key_q, value_q;

  logic             in_fire, commit, cfg_wr;
  logic             re;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata, rdata;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] hit_idx, victim_idx;
  logic [CMP_W-1:0] cap_ext, cap_eff;
  logic             full, cap_zero;
  logic [31:0]      count_inc;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // effective capacity and fill check
  assign cap_ext  = CMP_W'(cap_q);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign cap_zero = (cap_eff == '0);
  assign full     = (CMP_W'(occ_q) >= cap_eff);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  assign re         = (state_q == S_SCAN);

  assign count_inc = (scan_res.hit_count == COUNT_MAX) ? COUNT_MAX
                                                      : scan_res.hit_count + 32'd1;

  // write-back decision
  always_comb begin
    we                = 1'b0;
    waddr             = hit_idx;
    wdata.key         = key_q;
    wdata.value       = value_q;
    wdata.use_count   = count_inc;
    wdata.last_access = clock_q;
    if (op_q == OP_GET) begin
      wdata.value = scan_res.hit_value;
      we          = scan_res.hit;
    end else if (!cap_zero) begin
      we = 1'b1;
      if (!scan_res.hit) begin
        wdata.use_count = COUNT_ONE;
        waddr           = full ? victim_idx : occ_q[IDX_W-1:0];
      end
    end
    we = we && commit;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    clock_d     = clock_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    rdv_d       = rdv_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          state_d = (occ_q == '0) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + OCC_W'(1);
        if (cnt_q + OCC_W'(1) == occ_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          hit_d       = scan_res.hit;
          rdv_d       = (op_q == OP_GET && scan_res.hit) ? scan_res.hit_value
                                                         : MISS_VALUE;
          if (we) begin
            clock_d = clock_q + 64'd1;
          end
          if (we && op_q == OP_PUT && !scan_res.hit && !full) begin
            occ_d = occ_q + OCC_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= re;
      hit_q       <= hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rdv_q    <= rdv_d;
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (in_fire) begin
      op_q    <= opcode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  lfu_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  lfu_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_fire),
    .rd_vld_i     (rd_vld_q),
    .rd_idx_i     (rd_idx_q),
    .rd_data_i    (rdata),
    .key_i        (key_q),
    .res_o        (scan_res),
    .hit_idx_o    (hit_idx),
    .victim_idx_o (victim_idx)
  );

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdv_q;

endmodule

// ----- rtl/lfu_chk.sv -----
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks for the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic signed [31:0] read_value_o,
  input logic               pready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(read_value_o))
    else $error("result changed while stalled");

  // results without a hit (misses, and puts that miss) report the all-ones value
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> read_value_o == 32'hFFFF_FFFF)
    else $error("miss without all-ones read value");

  // one request in flight: ready drops right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // no result appears in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result before lookup");

  // configuration port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_o        (hit_o),
  .read_value_o (read_value_o),
  .pready       (pready)
);
